FILE: hw/rtl/lflbp_pkg.sv
// ----------------------------------------------------------------------------
// lflbp_pkg: shared types and constants of the block pool allocator
// Sizes, register map, command and status codes, control/status structs.
// ----------------------------------------------------------------------------
package lflbp_pkg;

  // pool geometry
  localparam int BLOCKS = 1024;
  localparam int IDX_W  = $clog2(BLOCKS);
  localparam int CNT_W  = $clog2(BLOCKS + 1);
  // link memory entry: {linked, successor}
  localparam int ENTRY_W = CNT_W + 1;

  // field and register widths
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 17;
  localparam int BCNT_W = 11;
  localparam int PREP_W = 11;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W = REG_IDX_W + 2;
  localparam int STEP_W = $clog2(ADDR_W + 1);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PREP  = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0] BASE_RST  = '0;
  localparam logic [SIZE_W-1:0] SIZE_RST  = 17'd64;
  localparam logic [BCNT_W-1:0] COUNT_RST = 11'd1024;
  localparam logic [PREP_W-1:0] PREP_RST  = 11'd1;

  // command and status codes
  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_FREE   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  // configuration write
  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [APB_DW-1:0]    data;
  } cfg_wr_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;    // latch the input transaction
    logic clr_step;   // clear one link entry
    logic mul_go;     // register index times block size
    logic alloc_fin;  // pop head, load output register
    logic div_start;  // launch offset division
    logic free_wr;    // push freed block if in range
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             clr_last;
    logic             below_base;
    logic             div_busy;
    logic             div_done;
    logic             out_full;
    logic [CNT_W-1:0] head;
    logic [CNT_W-1:0] count;
  } stat_t;

  // block_count clamped to 1..BLOCKS
  function automatic logic [CNT_W-1:0] eff_count(input logic [BCNT_W-1:0] bc);
    logic [CNT_W-1:0] n;
    if (bc == '0) begin
      n = CNT_W'(1);
    end else if (32'(bc) > BLOCKS) begin
      n = CNT_W'(BLOCKS);
    end else begin
      n = CNT_W'(bc);
    end
    return n;
  endfunction

  // block_size of zero acts as one
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] bs);
    return (bs == '0) ? SIZE_W'(1) : bs;
  endfunction

endpackage

FILE: hw/rtl/lflbp_div.sv
// ----------------------------------------------------------------------------
// lflbp_div: radix-2 restoring divider
// One quotient bit per cycle; 32-bit dividend by a 17-bit divisor.
// ----------------------------------------------------------------------------
module lflbp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lflbp_pkg::ADDR_W-1:0] dividend,
  input  logic [lflbp_pkg::SIZE_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [lflbp_pkg::ADDR_W-1:0] quotient
);

  logic [lflbp_pkg::SIZE_W-1:0] dsr;
  logic [lflbp_pkg::SIZE_W-1:0] rem;
  logic [lflbp_pkg::ADDR_W-1:0] quo;
  logic [lflbp_pkg::STEP_W-1:0] cnt;
  logic [lflbp_pkg::SIZE_W:0]   shifted;
  logic [lflbp_pkg::SIZE_W:0]   diff;
  logic                         fits;

  // one restoring step
  assign shifted = {rem, quo[lflbp_pkg::ADDR_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= lflbp_pkg::STEP_W'(lflbp_pkg::ADDR_W);
      end else if (busy) begin
        cnt <= cnt - lflbp_pkg::STEP_W'(1);
        if (cnt == lflbp_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[lflbp_pkg::SIZE_W-1:0] : shifted[lflbp_pkg::SIZE_W-1:0];
      quo <= {quo[lflbp_pkg::ADDR_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

FILE: hw/rtl/lflbp_dp.sv
// ----------------------------------------------------------------------------
// lflbp_dp: allocator datapath
// Config registers, head pointer, link memory, multiplier, divider, output reg.
// ----------------------------------------------------------------------------
module lflbp_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lflbp_pkg::cmd_t                cmd,
  output lflbp_pkg::stat_t               st,
  input  lflbp_pkg::cfg_wr_t             cfg,
  input  logic [lflbp_pkg::REG_IDX_W-1:0] rd_idx,
  output logic [lflbp_pkg::APB_DW-1:0]    rd_data,
  input  logic [lflbp_pkg::ADDR_W-1:0]    in_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic [lflbp_pkg::ADDR_W-1:0]    out_addr
);

  // configuration registers
  logic [lflbp_pkg::ADDR_W-1:0] base;
  logic [lflbp_pkg::SIZE_W-1:0] bsize;
  logic [lflbp_pkg::BCNT_W-1:0] bcount;
  logic [lflbp_pkg::PREP_W-1:0] prep;

  logic [lflbp_pkg::CNT_W-1:0]  n;
  logic [lflbp_pkg::SIZE_W-1:0] sz;

  // working state
  logic [lflbp_pkg::CNT_W-1:0]  head;
  logic [lflbp_pkg::CNT_W-1:0]  head_next;
  logic [lflbp_pkg::IDX_W-1:0]  head_idx;
  logic [lflbp_pkg::IDX_W-1:0]  clr_cnt;
  logic [lflbp_pkg::ADDR_W-1:0] addr_q;
  logic [lflbp_pkg::IDX_W+lflbp_pkg::SIZE_W-1:0] prod;

  // link memory
  logic [lflbp_pkg::ENTRY_W-1:0] mem [lflbp_pkg::BLOCKS];
  logic [lflbp_pkg::ENTRY_W-1:0] rd_q;
  logic                          mem_we;
  logic [lflbp_pkg::IDX_W-1:0]   mem_wa;
  logic [lflbp_pkg::ENTRY_W-1:0] mem_wd;

  // divider
  logic                         div_busy;
  logic                         div_done;
  logic [lflbp_pkg::ADDR_W-1:0] quo;
  logic                         oom;
  logic                         q_ok;
  logic [lflbp_pkg::CNT_W-1:0]  nxt;
  logic [lflbp_pkg::CNT_W-1:0]  link_val;

  assign n        = lflbp_pkg::eff_count(bcount);
  assign sz       = lflbp_pkg::eff_size(bsize);
  assign head_idx = head[lflbp_pkg::IDX_W-1:0];
  assign oom      = head >= n;
  assign q_ok     = quo < lflbp_pkg::ADDR_W'(n);

  // config write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= lflbp_pkg::BASE_RST;
      bsize  <= lflbp_pkg::SIZE_RST;
      bcount <= lflbp_pkg::COUNT_RST;
      prep   <= lflbp_pkg::PREP_RST;
    end else if (cfg.we) begin
      unique case (cfg.idx)
        lflbp_pkg::REG_BASE:  base   <= cfg.data;
        lflbp_pkg::REG_SIZE:  bsize  <= cfg.data[lflbp_pkg::SIZE_W-1:0];
        lflbp_pkg::REG_COUNT: bcount <= cfg.data[lflbp_pkg::BCNT_W-1:0];
        lflbp_pkg::REG_PREP:  prep   <= cfg.data[lflbp_pkg::PREP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rd_idx)
      lflbp_pkg::REG_BASE:  rd_data = base;
      lflbp_pkg::REG_SIZE:  rd_data = lflbp_pkg::APB_DW'(bsize);
      lflbp_pkg::REG_COUNT: rd_data = lflbp_pkg::APB_DW'(bcount);
      lflbp_pkg::REG_PREP:  rd_data = lflbp_pkg::APB_DW'(prep);
      default:              rd_data = '0;
    endcase
  end

  // successor of the head: stored link, else the next index
  assign nxt       = rd_q[lflbp_pkg::CNT_W] ? rd_q[lflbp_pkg::CNT_W-1:0]
                                            : head + lflbp_pkg::CNT_W'(1);
  assign head_next = (nxt < n) ? nxt : n;
  assign link_val  = (head < n) ? head : n;

  // head pointer and clear counter
  always_ff @(posedge clk) begin
    if (rst || cfg.we) begin
      head    <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + lflbp_pkg::IDX_W'(1);
      end
      if (cmd.alloc_fin && !oom) begin
        head <= head_next;
      end else if (cmd.free_wr && q_ok) begin
        head <= lflbp_pkg::CNT_W'(quo);
      end
    end
  end

  // memory write port: clearing pass or free push
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt;
    mem_wd = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.free_wr && q_ok) begin
      mem_we = 1'b1;
      mem_wa = quo[lflbp_pkg::IDX_W-1:0];
      mem_wd = {1'b1, link_val};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[head_idx];
  end

  // input latch and address product
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      addr_q <= in_addr;
    end
    if (cmd.mul_go) begin
      prod <= head_idx * sz;
    end
  end

  lflbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (addr_q - base),
    .divisor  (sz),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.alloc_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_fin) begin
      out_status <= oom ? lflbp_pkg::STATUS_OOM : lflbp_pkg::STATUS_OK;
      out_addr   <= oom ? '0 : base + lflbp_pkg::ADDR_W'(prod);
    end
  end

  // status
  assign st.clr_last   = clr_cnt == lflbp_pkg::IDX_W'(lflbp_pkg::BLOCKS - 1);
  assign st.below_base = addr_q < base;
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.out_full   = out_valid & ~out_ready;
  assign st.head       = head;
  assign st.count      = n;

endmodule

FILE: hw/rtl/lflbp_ctrl.sv
// ----------------------------------------------------------------------------
// lflbp_ctrl: allocator controller
// Sequences clearing pass, allocate and free transactions.
// ----------------------------------------------------------------------------
module lflbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  lflbp_pkg::stat_t  st,
  output lflbp_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_A_MUL = 3'd2;
  localparam logic [2:0] S_A_FIN = 3'd3;
  localparam logic [2:0] S_F_CHK = 3'd4;
  localparam logic [2:0] S_F_DIV = 3'd5;
  localparam logic [2:0] S_F_WR  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) & ~cfg_we;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take_in = 1'b1;
          state_next  = (in_cmd == lflbp_pkg::CMD_FREE) ? S_F_CHK : S_A_MUL;
        end
      end
      S_A_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_A_FIN;
      end
      S_A_FIN: begin
        if (!st.out_full) begin
          cmd.alloc_fin = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_F_CHK: begin
        if (st.below_base) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (st.div_done) begin
          state_next = S_F_WR;
        end
      end
      S_F_WR: begin
        cmd.free_wr = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // state register; a config write re-forms the pool
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/lazy_free_list_block_pool_top.sv
// ----------------------------------------------------------------------------
// lazy_free_list_block_pool_top: fixed-size block pool allocator
// Free list of block indices with lazily linked successors, APB config.
// ----------------------------------------------------------------------------
//  Channel   Dir  Transfer when                    Contents
//  s_*       in   s_tvalid & s_tready              tuser command, tdata free_address
//  m_*       out  m_tvalid & m_tready              tuser status, tdata block_address
//  APB       in   psel & penable & pwrite & pready register at paddr[3:2]
//
//  Allocate: the link is read and index times size registered, then base is added
//  and the result register loaded once a held result is taken, then back to idle.
//  Free: base check, 32-step radix-2 divide, then link push; below base stops there.
//  After reset and after every config write a clearing pass runs over all BLOCKS (1024)
//  link memory entries; s_tready is low during it.
//  A held result stalls only the next allocate; frees proceed underneath.
// ----------------------------------------------------------------------------
module lazy_free_list_block_pool_top (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lflbp_pkg::ADDR_W-1:0]       s_tdata,  // [31:0] free_address
  input  logic                              s_tuser,  // [0] command
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lflbp_pkg::ADDR_W-1:0]       m_tdata,  // [31:0] block_address
  output logic                              m_tuser,  // [0] status
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lflbp_pkg::PADDR_W-1:0]      paddr,
  input  logic [lflbp_pkg::APB_DW-1:0]       pwdata,
  output logic [lflbp_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  lflbp_pkg::cmd_t    cmd;
  lflbp_pkg::stat_t   st;
  lflbp_pkg::cfg_wr_t cfg;

  // APB decode
  assign pready   = 1'b1;
  assign cfg.we   = psel & penable & pwrite & pready;
  assign cfg.idx  = paddr[lflbp_pkg::PADDR_W-1:2];
  assign cfg.data = pwdata;

  lflbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.we),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lflbp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg        (cfg),
    .rd_idx     (paddr[lflbp_pkg::PADDR_W-1:2]),
    .rd_data    (prdata),
    .in_addr    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_addr   (m_tdata)
  );

  // no transaction accepted while the link memory is being cleared
  a_clr_blocks_in: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !s_tready)
    else $error("input accepted during clearing pass");

  // head never points past the end marker
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    st.head <= st.count)
    else $error("free list head beyond end marker");

  // divider idle whenever a new transaction may enter
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !st.div_busy)
    else $error("divider busy while ready for input");

endmodule

FILE: bench/lazy_free_list_block_pool_checker.sv
// ----------------------------------------------------------------------------
// lazy_free_list_block_pool_checker: result predictor and scoreboard
// Watches the config port and both streams, keeps its own copy of the free
// list, and compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module lazy_free_list_block_pool_checker
  import lflbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [ADDR_W-1:0]    s_tdata,   // [31:0] free_address
  input  logic                 s_tuser,   // [0] command
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [ADDR_W-1:0]    m_tdata,   // [31:0] block_address
  input  logic                 m_tuser,   // [0] status
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output int                   error_count,
  output int                   pending,
  output int                   results_checked,
  output int                   oom_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] block_address;
  } alloc_result_t;

  // shadow registers
  logic [ADDR_W-1:0] cfg_base;
  logic [SIZE_W-1:0] cfg_size;
  logic [BCNT_W-1:0] cfg_count;
  logic [PREP_W-1:0] cfg_prep;

  // shadow free list
  logic [CNT_W-1:0]  free_head;
  logic [CNT_W-1:0]  succ [BLOCKS];
  bit                succ_linked [BLOCKS];

  alloc_result_t     expected_allocs[$];

  initial begin
    error_count     = 0;
    pending         = 0;
    results_checked = 0;
    oom_results     = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns  pool check: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pool_blocks();
    if (cfg_count == '0) return 1;
    if (cfg_count > BLOCKS) return BLOCKS;
    return int'(cfg_count);
  endfunction

  function automatic logic [ADDR_W-1:0] block_bytes();
    return (cfg_size == '0) ? 32'd1 : 32'(cfg_size);
  endfunction

  // every register write starts the pool over
  function automatic void rebuild_pool();
    int n;
    int p;
    int i;
    n = pool_blocks();
    p = (cfg_prep == '0) ? 1 : int'(cfg_prep);
    if (p > n) p = n;
    for (i = 0; i < BLOCKS; i++) begin
      succ_linked[i] = (i < p);
      succ[i]        = (i < p) ? CNT_W'(i + 1) : '0;
    end
    free_head = '0;
  endfunction

  // pop the head; its successor gets linked on first touch
  function automatic alloc_result_t predict_alloc();
    int n;
    int blk;
    int nxt;
    alloc_result_t r;
    n = pool_blocks();
    if (free_head >= n) begin
      r.status        = STATUS_OOM;
      r.block_address = '0;
      return r;
    end
    blk = int'(free_head);
    nxt = int'(succ[blk]);
    if (nxt < n) begin
      if (!succ_linked[nxt]) begin
        succ_linked[nxt] = 1'b1;
        succ[nxt]        = CNT_W'(nxt + 1);
      end
      free_head = CNT_W'(nxt);
    end else begin
      free_head = CNT_W'(n);
    end
    r.status        = STATUS_OK;
    r.block_address = cfg_base + 32'(blk) * block_bytes();
    return r;
  endfunction

  // push the block back unless the address falls outside the pool
  function automatic void apply_free(input logic [ADDR_W-1:0] addr);
    int n;
    logic [ADDR_W-1:0] idx;
    n = pool_blocks();
    if (addr < cfg_base) return;
    idx = (addr - cfg_base) / block_bytes();
    if (idx >= 32'(n)) return;
    succ_linked[idx] = 1'b1;
    succ[idx]        = (free_head < n) ? free_head : CNT_W'(n);
    free_head        = CNT_W'(idx);
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      cfg_base  = BASE_RST;
      cfg_size  = SIZE_RST;
      cfg_count = COUNT_RST;
      cfg_prep  = PREP_RST;
      rebuild_pool();
      expected_allocs.delete();
    end else begin
      // result side first: a result never belongs to a same-edge input
      if (m_tvalid && m_tready) begin
        if (expected_allocs.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d addr=%h",
                                    m_tuser, m_tdata));
        end else begin
          want = expected_allocs.pop_front();
          results_checked++;
          if (want.status == STATUS_OOM) oom_results++;
          if (m_tuser !== want.status)
            report_mismatch($sformatf("status got %0d, want %0d", m_tuser, want.status));
          if (m_tdata !== want.block_address)
            report_mismatch($sformatf("block_address got %h, want %h",
                                      m_tdata, want.block_address));
        end
      end
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE:  cfg_base  = pwdata;
          REG_SIZE:  cfg_size  = pwdata[SIZE_W-1:0];
          REG_COUNT: cfg_count = pwdata[BCNT_W-1:0];
          REG_PREP:  cfg_prep  = pwdata[PREP_W-1:0];
          default: ;
        endcase
        rebuild_pool();
      end
      // command transaction
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_ALLOC) expected_allocs.push_back(predict_alloc());
        else apply_free(s_tdata);
      end
    end
    pending = expected_allocs.size();
  end

endmodule

FILE: bench/lazy_free_list_block_pool_top_tb.sv
// ----------------------------------------------------------------------------
// lazy_free_list_block_pool_top_tb: block pool allocator testbench
// Drives allocate/free commands and pool settings over APB, with random idle
// input cycles and result back-pressure; the checker predicts and scores results.
// ----------------------------------------------------------------------------
module lazy_free_list_block_pool_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lflbp_pkg::*;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int SETTLE_CYCLES   = 48;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ADDR_W-1:0]   s_tdata  = '0;   // [31:0] free_address
  logic                s_tuser  = 1'b0; // [0] command
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [ADDR_W-1:0]   m_tdata;         // [31:0] block_address
  logic                m_tuser;         // [0] status
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [APB_DW-1:0]   pwdata   = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int error_count;
  int pending;
  int results_checked;
  int oom_results;

  int tx_idle_pct = 35;
  int rx_idle_pct = 63;
  int items_sent  = 0;
  int frees_sent  = 0;
  int reg_writes  = 0;

  // pool settings as last written
  logic [ADDR_W-1:0] wr_base  = BASE_RST;
  logic [SIZE_W-1:0] wr_size  = SIZE_RST;
  logic [BCNT_W-1:0] wr_count = COUNT_RST;
  logic [PREP_W-1:0] wr_prep  = PREP_RST;

  lazy_free_list_block_pool_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lazy_free_list_block_pool_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .error_count     (error_count),
    .pending         (pending),
    .results_checked (results_checked),
    .oom_results     (oom_results)
  );

  // 50 MHz
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // run limit
  initial begin
    #10_000_000;
    $display("lazy_free_list_block_pool_top_tb: done, errors");
    $finish;
  end

  // all stimulus tasks start and end on a falling edge
  task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= addr;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
    if (cmd == CMD_FREE) frees_sent++;
  endtask

  // wait out a trailing free or the start of a clearing pass, then write
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    repeat (SETTLE_CYCLES) @(negedge clk);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // unused upper bits of the write data carry noise
  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                          input logic [BCNT_W-1:0] count, input logic [PREP_W-1:0] prep);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    apb_write(REG_BASE,  base);
    apb_write(REG_SIZE,  {15'($urandom()), size});
    apb_write(REG_COUNT, {21'($urandom()), count});
    apb_write(REG_PREP,  {21'($urandom()), prep});
    wr_base  = base;
    wr_size  = size;
    wr_count = count;
    wr_prep  = prep;
  endtask

  function automatic logic [ADDR_W-1:0] block_addr(input int unsigned idx,
                                                    input int unsigned off);
    return wr_base + 32'(idx) * 32'(eff_size(wr_size)) + 32'(off);
  endfunction

  task automatic random_pool();
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [BCNT_W-1:0] count;
    logic [PREP_W-1:0] prep;
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = 32'hFFFF_0000 | 32'($urandom_range(16'hFFFF));
      default: base = $urandom();
    endcase
    case ($urandom_range(5))
      0:       size = '0;
      1:       size = 17'h10000;
      2:       size = 17'($urandom_range(8, 1));
      3:       size = 17'd1 << $urandom_range(16);
      4:       size = 17'($urandom_range(65536, 1));
      default: size = 17'($urandom());
    endcase
    // mostly small pools, so the list runs dry and blocks get reused
    case ($urandom_range(5))
      0:       count = '0;
      1:       count = 11'd1024;
      2:       count = 11'($urandom_range(2047, 1025));
      3:       count = 11'($urandom_range(200, 13));
      default: count = 11'($urandom_range(12, 1));
    endcase
    case ($urandom_range(3))
      0:       prep = '0;
      1:       prep = 11'($urandom());
      default: prep = 11'($urandom_range(count + 2));
    endcase
    set_pool(base, size, count, prep);
  endtask

  // allocates, in-pool frees at any offset, and some stray addresses
  task automatic random_item();
    int unsigned n;
    int unsigned sz;
    int unsigned idx;
    int unsigned pick;
    n    = eff_count(wr_count);
    sz   = eff_size(wr_size);
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_item(CMD_ALLOC, $urandom());
    end else if (pick < 88) begin
      idx = ($urandom_range(9) == 0) ? n + $urandom_range(2) : $urandom_range(n - 1);
      send_item(CMD_FREE, block_addr(idx, $urandom_range(sz - 1)));
    end else if (pick < 94 && wr_base != '0) begin
      send_item(CMD_FREE, $urandom_range(wr_base - 1));
    end else begin
      send_item(CMD_FREE, $urandom());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: lazy linking of the second block, reuse after free
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_ALLOC, 32'hFFFF_FFFF);
    send_item(CMD_FREE,  block_addr(1, 5));
    send_item(CMD_ALLOC, 32'h0);

    // three blocks: exhaustion, stray frees, free into empty list, double free
    set_pool(32'h0000_1000, 17'd16, 11'd3, 11'd0);
    repeat (4) send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'h0000_0FFF);
    send_item(CMD_FREE, 32'h0000_1030);
    send_item(CMD_FREE, 32'h0000_101F);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'h0000_1000);
    send_item(CMD_FREE, 32'h0000_1000);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_ALLOC, 32'h0);

    // largest settings: address wrap past 2^32, free below base
    set_pool(32'hFFFF_FFFF, 17'h10000, 11'd2047, 11'd2047);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE,  32'hFFFF_FFFF);
    send_item(CMD_FREE,  32'h0000_0000);
    send_item(CMD_ALLOC, 32'h0);

    // zero size, count and prepared count all act as one
    set_pool(32'h0, 17'd0, 11'd0, 11'd0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE,  32'h1);
    send_item(CMD_FREE,  32'h0);
    send_item(CMD_ALLOC, 32'h0);

    // random phases: receiver-light, then sender-light, then no idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) begin
        tx_idle_pct = 63;
        rx_idle_pct = 35;
      end else if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_pool();
      repeat (ITEMS_PER_PHASE) random_item();
    end

    // drain
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands (%0d frees) over %0d register writes",
             items_sent, frees_sent, reg_writes);
    $display("checked %0d allocate results, %0d of them out of memory",
             results_checked, oom_results);
    if (error_count == 0) begin
      $display("lazy_free_list_block_pool_top_tb: done, clean");
    end else begin
      $display("lazy_free_list_block_pool_top_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lflbp_pkg.sv
hw/rtl/lflbp_div.sv
hw/rtl/lflbp_dp.sv
hw/rtl/lflbp_ctrl.sv
hw/rtl/lazy_free_list_block_pool_top.sv
bench/lazy_free_list_block_pool_checker.sv
bench/lazy_free_list_block_pool_top_tb.sv
